// File: hw/rtl/blt_pkg.sv
// ---------------------------------------------------------------------------
// blt_pkg: shared types for the bounded list table unit
// Operation codes, transfer payload structs and controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package blt_pkg;

  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_DEL_VALUE = 3'd1;
  localparam logic [2:0] KIND_DEL_INDEX = 3'd2;
  localparam logic [2:0] KIND_FIND      = 3'd3;
  localparam logic [2:0] KIND_GET       = 3'd4;
  localparam logic [2:0] KIND_SET       = 3'd5;

  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int VAL_W = 32;

  typedef struct packed {
    logic [2:0]              kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    logic                    is_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_list_table_unit.sv
// ---------------------------------------------------------------------------
// bounded_list_table_unit: packed list of signed 32-bit values
// Append, delete by value or index, find, get and set on a list held in a
// single-port-read, single-port-write synchronous memory of CAPACITY entries.
// ---------------------------------------------------------------------------
// Usage:
//   An item transfers when start is high and busy is low. Each item yields
//   exactly one result, shown for one cycle with out_valid high; the
//   receiver cannot stall, so results are never held.
//   Sequence from accept to out_valid:
//     append, set, failed ops      result registered, busy stays low (next item next cycle)
//     get                          memory read, then result
//     find                         scan of up to length entries (one entry per cycle)
//     delete value                 search as find, then the shift below
//     delete index                 shift of the entries above position,
//                                  none when the last entry goes
//   The registered memory read port paces both loops: the search compares one
//   entry per cycle, and the gap-closing shift moves one entry per cycle,
//   writing each entry in the cycle after its read.
//   Reset clears the length to zero and idles the controller; memory
//   contents are not cleared, entries past the length are never read.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_list_table_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire blt_pkg::in_item_t in_data,
  output logic                   out_valid,
  output blt_pkg::out_item_t     out_data
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > blt_pkg::POS_W) ? CNT_W : blt_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic signed [31:0] mem [CAPACITY];

  blt_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  blt_pkg::in_item_t  op_r, op_nxt;
  blt_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] rd_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic               accept;
  logic               hit;
  logic               res_ok;
  logic [blt_pkg::POS_W-1:0] res_fpos;
  logic signed [31:0] res_val;

  assign accept  = start && (state_r == blt_pkg::ST_IDLE);
  assign pos_ext = CMP_W'(in_data.position);
  assign cnt_ext = CMP_W'(count_r);
  assign hit     = rd_vld_r && (rd_q == op_r.value);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blt_pkg::ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    op_r     <= op_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    res_ok        = 1'b0;
    res_fpos      = '0;
    res_val       = '0;

    unique case (state_r)
      blt_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt = in_data;
          unique case (in_data.kind)
            blt_pkg::KIND_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r < CAP_CNT) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IDX_W-1:0];
                wr_data   = in_data.value;
                count_nxt = count_r + CNT_W'(1);
                res_ok    = 1'b1;
                res_val   = in_data.value;
              end
            end
            blt_pkg::KIND_SET: begin
              out_valid_nxt = 1'b1;
              if (pos_ext < CMP_W'(CAPACITY)) begin
                wr_en   = 1'b1;
                wr_addr = pos_ext[IDX_W-1:0];
                wr_data = in_data.value;
                res_ok  = 1'b1;
              end
            end
            blt_pkg::KIND_GET: begin
              if (pos_ext < cnt_ext) begin
                rd_en     = 1'b1;
                rd_addr   = pos_ext[IDX_W-1:0];
                state_nxt = blt_pkg::ST_GET;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            blt_pkg::KIND_DEL_INDEX: begin
              if (pos_ext < cnt_ext) begin
                ptr_nxt   = pos_ext[CNT_W-1:0] + CNT_W'(1);
                state_nxt = blt_pkg::ST_SHIFT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            blt_pkg::KIND_FIND, blt_pkg::KIND_DEL_VALUE: begin
              if (count_r != '0) begin
                ptr_nxt   = '0;
                state_nxt = blt_pkg::ST_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      blt_pkg::ST_GET: begin
        out_valid_nxt = 1'b1;
        res_ok        = 1'b1;
        res_val       = rd_q;
        state_nxt     = blt_pkg::ST_IDLE;
      end

      blt_pkg::ST_SCAN: begin
        // reads run one entry ahead of the compare
        if (hit) begin
          if (op_r.kind == blt_pkg::KIND_FIND) begin
            out_valid_nxt = 1'b1;
            res_ok        = 1'b1;
            res_fpos      = blt_pkg::POS_W'(rd_idx_r);
            state_nxt     = blt_pkg::ST_IDLE;
          end else begin
            ptr_nxt   = CNT_W'(rd_idx_r) + CNT_W'(1);
            state_nxt = blt_pkg::ST_SHIFT;
          end
        end else if (ptr_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = ptr_r[IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + CNT_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = blt_pkg::ST_IDLE;
        end
      end

      blt_pkg::ST_SHIFT: begin
        // read entry k, write it to k-1 in the following cycle; reads stay above writes
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r - IDX_W'(1);
          wr_data = rd_q;
        end
        if (ptr_r < count_r) begin
          rd_en      = 1'b1;
          rd_addr    = ptr_r[IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          count_nxt     = count_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          res_ok        = 1'b1;
          state_nxt     = blt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = blt_pkg::ST_IDLE;
      end
    endcase

    out_nxt.ok             = res_ok;
    out_nxt.found_position = res_fpos;
    out_nxt.read_value     = res_val;
    out_nxt.length         = blt_pkg::LEN_W'(count_nxt);
    out_nxt.is_empty       = (count_nxt == '0);
  end

  assign busy      = (state_r != blt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for bounded_list_table_unit
// Drives list operations through the start/busy port: a directed table with
// empty-list, extreme-value and out-of-range cases, then random epochs that
// grow the list toward full, hold it and shrink it. Each result is checked
// field by field against the table or a list model kept in this testbench.
// ----------------------------------------------------------------------------
module testbench;
  import blt_pkg::*;

  localparam int CAP          = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int SETTLE_CYCLES = 2 * CAP + 8;  // worst-case shift plus margin

  // kinds the block treats as no-ops
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {MIX_GROW, MIX_STEADY, MIX_SHRINK} mix_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  // list model
  logic signed [31:0] list_mem [CAP];
  int                 list_len;
  logic signed [31:0] value_pool [8];

  out_item_t pending_results [$];
  int        mismatch_count;

  bounded_list_table_unit #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic in_item_t cmd(logic [2:0] kind, int pos, logic signed [31:0] val);
    in_item_t it;
    it.kind     = kind;
    it.position = pos[5:0];
    it.value    = val;
    return it;
  endfunction

  function automatic out_item_t res(bit ok, int fpos, logic signed [31:0] rval, int len,
                                    bit empty);
    out_item_t r;
    r.ok             = ok;
    r.found_position = fpos[5:0];
    r.read_value     = rval;
    r.length         = len[6:0];
    r.is_empty       = empty;
    return r;
  endfunction

  function automatic void close_gap(int idx);
    for (int k = idx + 1; k < list_len; k++) list_mem[k-1] = list_mem[k];
    list_len--;
  endfunction

  // Applies one operation to the list model and returns the result it yields.
  function automatic out_item_t list_apply(in_item_t it);
    out_item_t r;
    int        hit;
    r   = '0;
    hit = -1;
    for (int k = list_len - 1; k >= 0; k--) if (list_mem[k] == it.value) hit = k;
    case (it.kind)
      KIND_APPEND: if (list_len < CAP) begin
        list_mem[list_len] = it.value;
        list_len++;
        r.ok         = 1'b1;
        r.read_value = it.value;
      end
      KIND_DEL_VALUE: if (hit >= 0) begin
        close_gap(hit);
        r.ok = 1'b1;
      end
      KIND_DEL_INDEX: if (int'(it.position) < list_len) begin
        close_gap(int'(it.position));
        r.ok = 1'b1;
      end
      KIND_FIND: if (hit >= 0) begin
        r.ok             = 1'b1;
        r.found_position = hit[5:0];
      end
      KIND_GET: if (int'(it.position) < list_len) begin
        r.ok         = 1'b1;
        r.read_value = list_mem[it.position];
      end
      KIND_SET: if (int'(it.position) < CAP) begin
        list_mem[it.position] = it.value;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.length   = list_len[6:0];
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t random_item(mix_t mix);
    int unsigned pick;
    int unsigned cut [6];
    in_item_t    it;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   cut = '{70, 73, 76, 84, 92, 97};
      MIX_SHRINK: cut = '{5, 30, 65, 78, 90, 95};
      default:    cut = '{25, 37, 50, 65, 80, 95};
    endcase
    if (pick < cut[0])      it.kind = KIND_APPEND;
    else if (pick < cut[1]) it.kind = KIND_DEL_VALUE;
    else if (pick < cut[2]) it.kind = KIND_DEL_INDEX;
    else if (pick < cut[3]) it.kind = KIND_FIND;
    else if (pick < cut[4]) it.kind = KIND_GET;
    else if (pick < cut[5]) it.kind = KIND_SET;
    else                    it.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
    // small value pool makes matches and duplicates common
    it.value = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 7)]
                                           : $urandom;
    if (list_len > 0 && $urandom_range(0, 4) != 0)
      it.position = 6'($urandom_range(0, list_len - 1));
    else
      it.position = 6'($urandom_range(0, CAP - 1));
    return it;
  endfunction

  // Holds start high until the transfer, then books its expected result.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(start && !busy));
    pred = list_apply(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (pending_results.size() != 0) begin
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending: expected none, actual %p",
                 $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, out_data.ok);
        check_field("found_position", want.found_position, out_data.found_position);
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("length", want.length, out_data.length);
        check_field("is_empty", want.is_empty, out_data.is_empty);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t plan [$];
    mix_t      mix;
    int        rand_items;
    int        ep_len;
    bit        calm;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    list_len       = 0;
    rand_items     = 0;
    value_pool     = '{32'sd0, -32'sd1, VAL_MIN, VAL_MAX, $urandom, $urandom, $urandom,
                       $urandom};

    // empty-list cases and no-op kinds
    plan.push_back('{cmd(KIND_GET, 0, 0), 1'b1, res(0, 0, 0, 0, 1)});
    plan.push_back('{cmd(KIND_DEL_VALUE, 0, VAL_MIN), 1'b1, res(0, 0, 0, 0, 1)});
    plan.push_back('{cmd(KIND_DEL_INDEX, 0, 0), 1'b1, res(0, 0, 0, 0, 1)});
    plan.push_back('{cmd(KIND_FIND, 0, 0), 1'b1, res(0, 0, 0, 0, 1)});
    plan.push_back('{cmd(KIND_SPARE6, 63, -1), 1'b1, res(0, 0, 0, 0, 1)});
    plan.push_back('{cmd(KIND_SPARE7, 63, VAL_MAX), 1'b1, res(0, 0, 0, 0, 1)});
    // extreme values, with a duplicate for first-match checks
    plan.push_back('{cmd(KIND_APPEND, 63, VAL_MAX), 1'b1, res(1, 0, VAL_MAX, 1, 0)});
    plan.push_back('{cmd(KIND_APPEND, 0, VAL_MIN), 1'b1, res(1, 0, VAL_MIN, 2, 0)});
    plan.push_back('{cmd(KIND_APPEND, 0, 0), 1'b1, res(1, 0, 0, 3, 0)});
    plan.push_back('{cmd(KIND_APPEND, 0, -1), 1'b1, res(1, 0, -1, 4, 0)});
    plan.push_back('{cmd(KIND_APPEND, 0, 0), 1'b1, res(1, 0, 0, 5, 0)});
    plan.push_back('{cmd(KIND_FIND, 0, 0), 1'b0, '0});
    plan.push_back('{cmd(KIND_FIND, 63, -1), 1'b0, '0});
    plan.push_back('{cmd(KIND_GET, 63, 0), 1'b1, res(0, 0, 0, 5, 0)});
    plan.push_back('{cmd(KIND_GET, 4, 0), 1'b0, '0});
    // set past the length writes storage but leaves the length alone
    plan.push_back('{cmd(KIND_SET, 63, 32'sh5A5A_5A5A), 1'b1, res(1, 0, 0, 5, 0)});
    plan.push_back('{cmd(KIND_SET, 0, -2), 1'b0, '0});
    plan.push_back('{cmd(KIND_DEL_VALUE, 0, 0), 1'b0, '0});
    plan.push_back('{cmd(KIND_DEL_INDEX, 0, 0), 1'b0, '0});
    plan.push_back('{cmd(KIND_DEL_INDEX, 63, 0), 1'b1, res(0, 0, 0, 3, 0)});
    plan.push_back('{cmd(KIND_FIND, 0, 12345), 1'b0, '0});
    plan.push_back('{cmd(KIND_GET, 0, 0), 1'b0, '0});
    plan.push_back('{cmd(KIND_DEL_INDEX, 2, 0), 1'b0, '0});
    plan.push_back('{cmd(KIND_SPARE6, 1, VAL_MIN), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].item, plan[i].typed, plan[i].want);
      idle_for(gap_cycles());
    end
    drain_results();

    // epochs: grow toward full, hold, shrink toward empty, repeat
    mix = MIX_GROW;
    while (rand_items < RANDOM_ITEMS) begin
      ep_len = (mix == MIX_STEADY) ? $urandom_range(60, 140) : $urandom_range(130, 200);
      calm   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ep_len && rand_items < RANDOM_ITEMS; n++) begin
        send_item(random_item(mix), 1'b0, '0);
        rand_items++;
        if (!calm) idle_for(gap_cycles());
      end
      if ($urandom_range(0, 1)) drain_results();
      case (mix)
        MIX_GROW:   mix = MIX_STEADY;
        MIX_STEADY: mix = MIX_SHRINK;
        default:    mix = MIX_GROW;
      endcase
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/blt_pkg.sv
hw/rtl/bounded_list_table_unit.sv
tb/testbench.sv
